[src/fefifo_pkg.sv]
// Package for the ring FIFO: sizes, command and error codes, transaction types
// and the controller-to-datapath command struct. No dependencies.
`default_nettype none
package fefifo_pkg;

  localparam int DEPTH         = 16;
  localparam int ELEMENT_BYTES = 4;
  localparam int ELEM_W        = 8 * ELEMENT_BYTES;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_POP       = 3'd1;
  localparam logic [2:0] CMD_PEEK_HEAD = 3'd2;
  localparam logic [2:0] CMD_PEEK_TAIL = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_PUSH_FULL  = 2'd1;
  localparam logic [1:0] ERR_POP_EMPTY  = 2'd2;
  localparam logic [1:0] ERR_PEEK_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] push_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  error_code;
    logic        is_empty;
    logic        is_full;
    logic [4:0]  stored_count;
    logic [4:0]  free_space;
  } result_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the queue and register the result
  } fefifo_ctl_t;

endpackage
`default_nettype wire

[src/fixed_element_ring_fifo.sv]
// Top level of the ring FIFO: controller plus datapath, and checks.
// Depends on fefifo_pkg, fefifo_ctrl, fefifo_dp.
//
//  channel   ports                          transfer
//  command   start, busy, in_item           start && !busy at a rising edge
//  result    done, result                   done high for one cycle, no stall
//  config    cfg_write_en, cfg_write_data   cfg_write_en at a rising edge
//
// A command is captured, then makes one pass through the store
// (one write or one registered read) that also updates the indices.
// done and the result follow in the next cycle, while busy is already low,
// so a new command can be taken while done is high; busy is high during the pass.
// Synchronous reset empties the queue and sets capacity to 16; the store is
// not cleared. A capacity write empties the queue as well.
`default_nettype none
module fixed_element_ring_fifo import fefifo_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            done,
  output result_t         result,
  input  wire logic       cfg_write_en,
  input  wire logic [4:0] cfg_write_data
);

  fefifo_ctl_t ctl;

  fefifo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  fefifo_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .in_item        (in_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result         (result)
  );

`ifndef SYNTHESIS
  // an accepted transaction always yields its result strobe after its pass
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("missing result strobe");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  a_full_no_space: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_full == (result.free_space == 5'd0)))
    else $error("full flag disagrees with free space");

  a_push_refused_full: assert property (@(posedge clk) disable iff (rst)
    done && result.error_code == ERR_PUSH_FULL |-> result.is_full)
    else $error("push refused while not full");
`endif

endmodule
`default_nettype wire

[src/fefifo_ctrl.sv]
// Controller for the ring FIFO: two-state sequencer plus the result strobe.
// Depends on fefifo_pkg.
`default_nettype none
module fefifo_ctrl import fefifo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  output fefifo_ctl_t      ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.exec;
    end
  end

  assign busy = (state == ST_EXEC);

endmodule
`default_nettype wire

[src/fefifo_dp.sv]
// Datapath for the ring FIFO: element store, indices, count, capacity register
// and the result register. Depends on fefifo_pkg.
`default_nettype none
module fefifo_dp import fefifo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fefifo_ctl_t ctl,
  input  wire in_item_t    in_item,
  input  wire logic        cfg_write_en,
  input  wire logic [4:0]  cfg_write_data,
  output result_t          result
);

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] mem_q;

  logic [2:0]        cmd;
  logic [31:0]       data;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cap;      // effective capacity, 1..DEPTH

  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [1:0]        err;
  logic [CNT_W-1:0]  cap_wr;

  logic              rd_sel;
  logic [1:0]        err_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  free_q;
  logic              full_q;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] wrap);
    logic [CNT_W-1:0] n;
    n = {1'b0, idx} + CNT_W'(1);
    return (n >= wrap) ? '0 : n[IDX_W-1:0];
  endfunction

  // out-of-range capacity clamps to 1..DEPTH
  always_comb begin
    if (cfg_write_data == '0) cap_wr = CNT_W'(1);
    else if (CNT_W'(cfg_write_data) > CNT_W'(DEPTH)) cap_wr = CNT_W'(DEPTH);
    else cap_wr = CNT_W'(cfg_write_data);
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    rd_addr    = head;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    err        = ERR_OK;
    case (cmd)
      CMD_PUSH: begin
        if (count >= cap) begin
          err = ERR_PUSH_FULL;
        end else begin
          wr_en      = 1'b1;
          tail_next  = advance(tail, cap);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          err = ERR_POP_EMPTY;
        end else begin
          rd_en      = 1'b1;
          head_next  = advance(head, cap);
          count_next = count - CNT_W'(1);
        end
      end
      CMD_PEEK_HEAD: begin
        if (count == '0) err = ERR_PEEK_EMPTY;
        else rd_en = 1'b1;
      end
      CMD_PEEK_TAIL: begin
        // newest element sits one behind the write slot
        rd_addr = (tail == '0) ? IDX_W'(cap - CNT_W'(1)) : tail - IDX_W'(1);
        if (count == '0) err = ERR_PEEK_EMPTY;
        else rd_en = 1'b1;
      end
      CMD_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) mem[tail] <= ELEM_W'(data);
    if (ctl.exec) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= CNT_W'(DEPTH);
    end else if (cfg_write_en) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= cap_wr;
    end else if (ctl.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd  <= in_item.command;
      data <= in_item.push_data;
    end
    if (ctl.exec) begin
      rd_sel  <= rd_en;
      err_q   <= err;
      count_q <= count_next;
      free_q  <= cap - count_next;
      full_q  <= (count_next >= cap);
    end
  end

  assign result.read_data    = rd_sel ? mem_q[31:0] : 32'd0;
  assign result.error_code   = err_q;
  assign result.is_empty     = (count_q == '0);
  assign result.is_full      = full_q;
  assign result.stored_count = 5'(count_q);
  assign result.free_space   = 5'(free_q);

endmodule
`default_nettype wire

[test/tb_fixed_element_ring_fifo.sv]
// Self-checking testbench for fixed_element_ring_fifo: directed table, then random
// command phases over many capacity settings, checked against a queue predictor.
// Depends on fefifo_pkg and the RTL of the ring FIFO.
`timescale 1ns / 100ps
module tb_fixed_element_ring_fifo;
  import fefifo_pkg::*;

  // commands 5..7 are unused and must act as no-ops
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int ITEM_TARGET = 1300;
  localparam int SHOW_LIMIT  = 40;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       start          = 1'b0;
  in_item_t   in_item        = '0;
  logic       cfg_write_en   = 1'b0;
  logic [4:0] cfg_write_data = '0;
  logic       busy;
  logic       done;
  result_t    result;

  fixed_element_ring_fifo uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .done           (done),
    .result         (result),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow queue
  logic [ELEM_W-1:0] shadow_store [DEPTH];
  int                q_head  = 0;
  int                q_tail  = 0;
  int                q_count = 0;
  logic [4:0]        cap_reg = 5'd16;

  result_t awaited_results [$];
  result_t head_want;

  int fail_count      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int full_hits       = 0;
  int err_hits [4]    = '{0, 0, 0, 0};

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] cap;
    in_item_t   item;
    logic       typed;
    result_t    want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t cmd_row(input logic [2:0] cmd, input logic [31:0] data);
    plan_row_t r;
    r = '0;
    r.item.command   = cmd;
    r.item.push_data = data;
    return r;
  endfunction

  function automatic plan_row_t chk_row(input logic [2:0] cmd, input logic [31:0] data,
                                        input logic [31:0] rd, input logic [1:0] err,
                                        input int emp, input int ful,
                                        input int cnt, input int fre);
    plan_row_t r;
    r = cmd_row(cmd, data);
    r.typed             = 1'b1;
    r.want.read_data    = rd;
    r.want.error_code   = err;
    r.want.is_empty     = (emp != 0);
    r.want.is_full      = (ful != 0);
    r.want.stored_count = 5'(cnt);
    r.want.free_space   = 5'(fre);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [4:0] v);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cap    = v;
    return r;
  endfunction

  // applies one command to the shadow queue and returns the status it reports
  function automatic result_t queue_outcome(input in_item_t it);
    result_t r;
    int      lim;
    lim = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    r = '0;
    case (it.command)
      CMD_PUSH: begin
        if (q_count >= lim) begin
          r.error_code = ERR_PUSH_FULL;
        end else begin
          shadow_store[q_tail] = it.push_data;
          q_tail = (q_tail + 1 >= lim) ? 0 : q_tail + 1;
          q_count++;
        end
      end
      CMD_POP: begin
        if (q_count == 0) begin
          r.error_code = ERR_POP_EMPTY;
        end else begin
          r.read_data = shadow_store[q_head];
          q_head = (q_head + 1 >= lim) ? 0 : q_head + 1;
          q_count--;
        end
      end
      CMD_PEEK_HEAD: begin
        if (q_count == 0) r.error_code = ERR_PEEK_EMPTY;
        else r.read_data = shadow_store[q_head];
      end
      CMD_PEEK_TAIL: begin
        if (q_count == 0) r.error_code = ERR_PEEK_EMPTY;
        else r.read_data = shadow_store[(q_tail == 0) ? lim - 1 : q_tail - 1];
      end
      CMD_CLEAR: begin
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
      end
      default: ;
    endcase
    r.is_empty     = (q_count == 0);
    r.is_full      = (q_count >= lim);
    r.stored_count = 5'(q_count);
    r.free_space   = 5'(lim - q_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // caller is at a rising edge; returns at the edge where the transaction was taken
  task automatic send_command(input in_item_t it, input logic typed, input result_t want);
    result_t predicted;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predicted = queue_outcome(it);
    err_hits[predicted.error_code]++;
    if (predicted.is_full) full_hits++;
    awaited_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [4:0] v);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cap_reg = v;
    q_head  = 0;
    q_tail  = 0;
    q_count = 0;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        head_want = awaited_results.pop_front();
        compare_field("read_data", result.read_data, head_want.read_data);
        compare_field("error_code", 32'(result.error_code), 32'(head_want.error_code));
        compare_field("is_empty", 32'(result.is_empty), 32'(head_want.is_empty));
        compare_field("is_full", 32'(result.is_full), 32'(head_want.is_full));
        compare_field("stored_count", 32'(result.stored_count),
                      32'(head_want.stored_count));
        compare_field("free_space", 32'(result.free_space), 32'(head_want.free_space));
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    int         phase_len;
    int         push_pct;
    int         pick;
    int         waited;
    logic       idle_on;
    logic [4:0] cap_pick;
    in_item_t   it;

    // capacity 16 out of reset
    plan.push_back(chk_row(CMD_POP, 32'h0, 32'h0, ERR_POP_EMPTY, 1, 0, 0, 16));
    plan.push_back(chk_row(CMD_PEEK_HEAD, 32'hFFFF_FFFF, 32'h0, ERR_PEEK_EMPTY, 1, 0, 0, 16));
    plan.push_back(chk_row(CMD_PEEK_TAIL, 32'h0, 32'h0, ERR_PEEK_EMPTY, 1, 0, 0, 16));
    plan.push_back(chk_row(CMD_PUSH, 32'hFFFF_FFFF, 32'h0, ERR_OK, 0, 0, 1, 15));
    plan.push_back(chk_row(CMD_PUSH, 32'h0, 32'h0, ERR_OK, 0, 0, 2, 14));
    plan.push_back(chk_row(CMD_PEEK_HEAD, 32'h0, 32'hFFFF_FFFF, ERR_OK, 0, 0, 2, 14));
    plan.push_back(chk_row(CMD_PEEK_TAIL, 32'hFFFF_FFFF, 32'h0, ERR_OK, 0, 0, 2, 14));
    plan.push_back(chk_row(CMD_RSVD_LO, 32'hFFFF_FFFF, 32'h0, ERR_OK, 0, 0, 2, 14));
    plan.push_back(chk_row(CMD_RSVD_HI, 32'h0, 32'h0, ERR_OK, 0, 0, 2, 14));
    plan.push_back(chk_row(CMD_POP, 32'h0, 32'hFFFF_FFFF, ERR_OK, 0, 0, 1, 15));
    plan.push_back(cmd_row(CMD_PUSH, 32'h1234_5678));
    plan.push_back(cmd_row(CMD_PEEK_TAIL, 32'h0));
    plan.push_back(chk_row(CMD_CLEAR, 32'h0, 32'h0, ERR_OK, 1, 0, 0, 16));
    // single-entry queue
    plan.push_back(cfg_row(5'd1));
    plan.push_back(chk_row(CMD_PUSH, 32'hA5A5_A5A5, 32'h0, ERR_OK, 0, 1, 1, 0));
    plan.push_back(chk_row(CMD_PUSH, 32'h5A5A_5A5A, 32'h0, ERR_PUSH_FULL, 0, 1, 1, 0));
    plan.push_back(chk_row(CMD_PEEK_TAIL, 32'h0, 32'hA5A5_A5A5, ERR_OK, 0, 1, 1, 0));
    plan.push_back(chk_row(CMD_POP, 32'h0, 32'hA5A5_A5A5, ERR_OK, 1, 0, 0, 1));
    // zero capacity behaves as one
    plan.push_back(cfg_row(5'd0));
    plan.push_back(chk_row(CMD_PUSH, 32'h3C3C_3C3C, 32'h0, ERR_OK, 0, 1, 1, 0));
    plan.push_back(chk_row(CMD_PUSH, 32'hC3C3_C3C3, 32'h0, ERR_PUSH_FULL, 0, 1, 1, 0));
    // oversize capacity clamps to the full depth
    plan.push_back(cfg_row(5'd31));
    plan.push_back(cmd_row(CMD_PUSH, 32'h8000_0001));
    plan.push_back(cmd_row(CMD_PUSH, 32'h7FFF_FFFE));
    plan.push_back(cmd_row(CMD_PEEK_TAIL, 32'h0));
    plan.push_back(cmd_row(CMD_POP, 32'h0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_capacity(plan[i].cap);
      end else begin
        send_command(plan[i].item, plan[i].typed, plan[i].want);
        idle_gap($urandom_range(0, 9));
      end
    end

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: cap_pick = 5'd0;
        1: cap_pick = 5'd1;
        2: cap_pick = 5'(DEPTH);
        3: cap_pick = 5'($urandom_range(DEPTH + 1, 31));
        4, 5, 6: cap_pick = 5'($urandom_range(2, 5));
        default: cap_pick = 5'($urandom_range(6, DEPTH - 1));
      endcase
      write_capacity(cap_pick);
      phase_len = $urandom_range(40, 120);
      push_pct  = $urandom_range(25, 75);
      idle_on   = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < phase_len; n++) begin
        // swap the bias halfway so phases both fill and drain
        if (n == phase_len / 2) push_pct = 100 - push_pct;
        case ($urandom_range(0, 9))
          0: it.push_data = 32'h0;
          1: it.push_data = 32'hFFFF_FFFF;
          default: it.push_data = $urandom();
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          it.command = CMD_CLEAR;
        end else if (pick < 5) begin
          it.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else if ($urandom_range(1, 100) <= push_pct) begin
          it.command = CMD_PUSH;
        end else begin
          case ($urandom_range(0, 4))
            0: it.command = CMD_PEEK_HEAD;
            1: it.command = CMD_PEEK_TAIL;
            default: it.command = CMD_POP;
          endcase
        end
        send_command(it, 1'b0, '0);
        idle_gap(idle_on ? $urandom_range(0, 9) : 0);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    repeat (4) @(posedge clk);

    $display("%0d transactions, %0d results checked, %0d capacity settings, %0d at full",
             items_sent, results_checked, cfg_writes, full_hits);
    $display("refused: push on full %0d, pop on empty %0d, peek on empty %0d",
             err_hits[ERR_PUSH_FULL], err_hits[ERR_POP_EMPTY], err_hits[ERR_PEEK_EMPTY]);
    if (fail_count == 0) begin
      $display("fixed_element_ring_fifo regression: pass");
    end else begin
      $display("fixed_element_ring_fifo regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout waiting on the block");
    $display("fixed_element_ring_fifo regression: fail");
    $finish;
  end

endmodule
